// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  // default configuration
  localparam int DEPTH_DEF     = 16;
  localparam int KEY_WIDTH_DEF = 16;

  // fixed port widths
  localparam int IN_KEY_W  = 16;
  localparam int OUT_KEY_W = 16;
  localparam int STATUS_W  = 2;
  localparam int FILL_W    = 5;

  // mode codes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // operation broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/sorted_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded ascending priority queue built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Each beat on the input channel is either an insert (mode 0) or a remove of
// the smallest key (mode 1), and produces exactly one result beat carrying the
// removed key, a status and the count held afterwards. Every cell compares its
// key with the incoming key in the same cycle, so a new beat is accepted every
// cycle, with the result in the next cycle in an output register. Input is
// stalled only while that register holds a result that is not being taken.
// No clearing pass is needed after reset; slots above the fill count are never
// read.
`default_nettype none

module sorted_priority_queue_core #(
  parameter int DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = spq_pkg::KEY_WIDTH_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_mode,
  input  wire logic [spq_pkg::IN_KEY_W-1:0]     in_key,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic      [spq_pkg::OUT_KEY_W-1:0]    out_key,
  output logic      [spq_pkg::STATUS_W-1:0]     out_status,
  output logic      [spq_pkg::FILL_W-1:0]       out_fill
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                            fire;
  logic                            is_full;
  logic                            is_empty;
  logic [KEY_WIDTH-1:0]            key_ext;
  spq_pkg::cell_ctrl_t             ctrl;

  logic [CNT_W-1:0]                count_r;
  logic [CNT_W-1:0]                count_nxt;

  logic                            out_valid_r;
  logic                            out_valid_nxt;
  logic [spq_pkg::OUT_KEY_W-1:0]   out_key_r;
  logic [spq_pkg::OUT_KEY_W-1:0]   out_key_nxt;
  logic [spq_pkg::STATUS_W-1:0]    out_status_r;
  logic [spq_pkg::STATUS_W-1:0]    out_status_nxt;

  logic [KEY_WIDTH-1:0]            entry  [DEPTH];
  logic                            gt     [DEPTH];

  // handshake and operation decode
  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);
  assign key_ext  = KEY_WIDTH'($signed(in_key));

  assign ctrl.ins = fire && (in_mode == spq_pkg::MODE_INSERT) && !is_full;
  assign ctrl.rem = fire && (in_mode == spq_pkg::MODE_REMOVE) && !is_empty;

  // chain of cells, smallest key in cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 occ;
    logic [KEY_WIDTH-1:0] lkey;
    logic                 lgt;
    logic [KEY_WIDTH-1:0] rkey;

    assign occ = (count_r > CNT_W'(i));

    if (i == 0) begin : g_first
      assign lkey = key_ext;
      assign lgt  = 1'b1;
    end else begin : g_mid
      assign lkey = entry[i-1];
      assign lgt  = gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rkey = entry[i];
    end else begin : g_inner
      assign rkey = entry[i+1];
    end

    spq_cell #(
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .new_key   (key_ext),
      .occupied  (occ),
      .left_key  (lkey),
      .left_gt   (lgt),
      .right_key (rkey),
      .entry     (entry[i]),
      .gt        (gt[i])
    );
  end

  // fill count
  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // result beat
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_key_nxt    = out_key_r;
    out_status_nxt = out_status_r;
    if (fire) begin
      out_valid_nxt  = 1'b1;
      out_key_nxt    = '0;
      out_status_nxt = spq_pkg::ST_DONE;
      if (in_mode == spq_pkg::MODE_INSERT) begin
        if (is_full) begin
          out_status_nxt = spq_pkg::ST_FULL;
        end
      end else begin
        if (is_empty) begin
          out_status_nxt = spq_pkg::ST_EMPTY;
        end else begin
          out_key_nxt = spq_pkg::OUT_KEY_W'($signed(entry[0]));
        end
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_key_r    <= out_key_nxt;
    out_status_r <= out_status_nxt;
  end

  // fill reported with the beat is the count after this step
  logic [spq_pkg::FILL_W-1:0] out_fill_r;
  logic [spq_pkg::FILL_W-1:0] out_fill_nxt;

  assign out_fill_nxt = fire ? spq_pkg::FILL_W'(count_nxt) : out_fill_r;

  always_ff @(posedge clk) begin
    out_fill_r <= out_fill_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_key    = out_key_r;
  assign out_status = out_status_r;
  assign out_fill   = out_fill_r;

endmodule

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds a key, compares it with the broadcast
// key and moves data to or from its neighbours.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell #(
  parameter int KEY_WIDTH = spq_pkg::KEY_WIDTH_DEF
) (
  input  wire                        clk,
  input  wire spq_pkg::cell_ctrl_t   ctrl,
  input  wire logic [KEY_WIDTH-1:0]  new_key,
  input  wire logic                  occupied,
  input  wire logic [KEY_WIDTH-1:0]  left_key,
  input  wire logic                  left_gt,
  input  wire logic [KEY_WIDTH-1:0]  right_key,
  output logic      [KEY_WIDTH-1:0]  entry,
  output logic                       gt
);

  logic [KEY_WIDTH-1:0] entry_r;
  logic [KEY_WIDTH-1:0] entry_nxt;

  // new key sorts after this slot's key
  assign gt    = occupied && ($signed(new_key) > $signed(entry_r));
  assign entry = entry_r;

  // insert: keep, take the new key, or take the left key; remove: shift left
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins) begin
      if (gt) begin
        entry_nxt = entry_r;
      end else if (left_gt) begin
        entry_nxt = new_key;
      end else begin
        entry_nxt = left_key;
      end
    end else if (ctrl.rem) begin
      entry_nxt = right_key;
    end
  end

  // key storage
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire
